/* src/hta_pkg.sv */
// ----------------------------------------------------------------------------
// hta_pkg
// Shared types and codes for the host traffic accounting table.
// ----------------------------------------------------------------------------
package hta_pkg;

   // request modes
   localparam logic [1:0] MODE_PKT   = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   // result status codes
   localparam logic [2:0] ST_SRC       = 3'd0;
   localparam logic [2:0] ST_DST       = 3'd1;
   localparam logic [2:0] ST_NOT_LOCAL = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_READ      = 3'd4;
   localparam logic [2:0] ST_FLUSHED   = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_NETS_IN_USE = 3'd0;
   localparam logic [2:0] CSR_NET_FIRST   = 3'd1;
   localparam logic [2:0] CSR_NET_LAST    = 3'd5;

   localparam int NET_REGS  = 5;
   localparam int NET_W     = 38;
   localparam int MIN_PLEN  = 8;
   localparam int MAX_PLEN  = 32;

   // classified job handed from front to back
   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  status;
      logic        seq_gap;
      logic [31:0] addr;
      logic [15:0] total_length;
      logic [31:0] timestamp;
      logic [4:0]  read_index;
   } job_type;

   // per-entry counters and stamps
   typedef struct packed {
      logic [63:0] src_packets;
      logic [63:0] src_bytes;
      logic [63:0] dst_packets;
      logic [63:0] dst_bytes;
      logic [31:0] first_stamp;
      logic [31:0] last_stamp;
   } entry_type;

   // one result
   typedef struct packed {
      logic [2:0]  status;
      logic        seq_gap;
      logic        entry_valid;
      logic [4:0]  entry_index;
      logic [31:0] host_addr;
      entry_type   data;
   } rsp_type;

   // address match against one packed prefix register
   function automatic logic prefix_hit(input logic [31:0] addr,
                                       input logic [NET_W-1:0] net);
      logic [5:0]  plen;
      logic [31:0] mask;
      plen = net[37:32];
      if (plen < 6'(MIN_PLEN)) plen = 6'(MIN_PLEN);
      if (plen > 6'(MAX_PLEN)) plen = 6'(MAX_PLEN);
      if (plen == 6'(MAX_PLEN)) mask = '1;
      else mask = ~(32'hFFFF_FFFF >> plen);
      return (addr & mask) == (net[31:0] & mask);
   endfunction

endpackage

/* src/hta_if.sv */
// ----------------------------------------------------------------------------
// hta_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] total_length;
   logic [31:0] timestamp;
   logic [31:0] log_seq;
   logic [4:0]  read_index;

   modport source (output valid, mode, src_addr, dst_addr, total_length, timestamp,
                   log_seq, read_index, input ready);
   modport sink   (input valid, mode, src_addr, dst_addr, total_length, timestamp,
                   log_seq, read_index, output ready);
endinterface

interface hta_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        seq_gap;
   logic        entry_valid;
   logic [4:0]  entry_index;
   logic [31:0] host_addr;
   logic [63:0] packets_as_source;
   logic [63:0] bytes_as_source;
   logic [63:0] packets_as_dest;
   logic [63:0] bytes_as_dest;
   logic [31:0] first_seen_time;
   logic [31:0] last_seen_time;

   modport source (output valid, status, seq_gap, entry_valid, entry_index, host_addr,
                   packets_as_source, bytes_as_source, packets_as_dest, bytes_as_dest,
                   first_seen_time, last_seen_time, input ready);
   modport sink   (input valid, status, seq_gap, entry_valid, entry_index, host_addr,
                   packets_as_source, bytes_as_source, packets_as_dest, bytes_as_dest,
                   first_seen_time, last_seen_time, output ready);
endinterface

/* src/host_traffic_accounting_table_top.sv */
// ----------------------------------------------------------------------------
// host_traffic_accounting_table_top
// Per-host IPv4 traffic accounting table with local prefix classification.
//
//   channel | dir | handshake   | content
//   req     | in  | valid/ready | mode, addresses, length, time, log seq, index
//   rsp     | out | valid/ready | status, seq gap, entry contents
//   csr     | in  | write only  | nets_in_use, local_net_0..4
//
// A request is classified in the front and queues for the table engine.
// Packet events search the table with one address read per used entry.
// The engine holds each result in its output register until taken, while the
// front keeps accepting into the two-entry queue. Reset is synchronous and
// leaves the table empty with no clearing pass.
// ----------------------------------------------------------------------------
module host_traffic_accounting_table_top
   import hta_pkg::*;
#(
   parameter int TABLE_ENTRIES  = 32,
   parameter int MAX_LOCAL_NETS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [NET_W-1:0] csr_wdata,
   hta_req_if.sink          req,
   hta_rsp_if.source        rsp
);

   logic    push, q_full, pop, q_not_empty;
   job_type push_job, head;
   rsp_type rsp_data;

   // front: classification and sequence check
   hta_front #(.MAX_LOCAL_NETS(MAX_LOCAL_NETS)) u_front (
      .clock, .reset, .csr_write_en, .csr_index, .csr_wdata,
      .in_valid(req.valid), .in_ready(req.ready), .in_mode(req.mode),
      .in_src_addr(req.src_addr), .in_dst_addr(req.dst_addr),
      .in_total_length(req.total_length), .in_timestamp(req.timestamp),
      .in_log_seq(req.log_seq), .in_read_index(req.read_index),
      .push, .push_job, .q_full
   );

   // job queue
   hta_queue u_queue (
      .clock, .reset, .push, .push_job, .full(q_full),
      .pop, .not_empty(q_not_empty), .head
   );

   // back: table engine
   hta_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .q_not_empty, .head, .pop,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp_data)
   );

   // result fields
   assign rsp.status            = rsp_data.status;
   assign rsp.seq_gap           = rsp_data.seq_gap;
   assign rsp.entry_valid       = rsp_data.entry_valid;
   assign rsp.entry_index       = rsp_data.entry_index;
   assign rsp.host_addr         = rsp_data.host_addr;
   assign rsp.packets_as_source = rsp_data.data.src_packets;
   assign rsp.bytes_as_source   = rsp_data.data.src_bytes;
   assign rsp.packets_as_dest   = rsp_data.data.dst_packets;
   assign rsp.bytes_as_dest     = rsp_data.data.dst_bytes;
   assign rsp.first_seen_time   = rsp_data.data.first_stamp;
   assign rsp.last_seen_time    = rsp_data.data.last_stamp;

endmodule

/* src/hta_front.sv */
// ----------------------------------------------------------------------------
// hta_front
// Holds configuration, classifies requests against local prefixes and
// checks the log sequence.
// ----------------------------------------------------------------------------
module hta_front
   import hta_pkg::*;
#(
   parameter int MAX_LOCAL_NETS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [NET_W-1:0]  csr_wdata,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_mode,
   input  logic [31:0]       in_src_addr,
   input  logic [31:0]       in_dst_addr,
   input  logic [15:0]       in_total_length,
   input  logic [31:0]       in_timestamp,
   input  logic [31:0]       in_log_seq,
   input  logic [4:0]        in_read_index,
   output logic              push,
   output job_type           push_job,
   input  logic              q_full
);

   logic [2:0]       nets_ff, nets_in;
   logic [NET_W-1:0] net_ff [NET_REGS];
   logic [31:0]      exp_seq_ff, exp_seq_in;
   logic             accept;
   logic [2:0]       n_used;
   logic             found;
   logic [2:0]       cls_status;
   logic [31:0]      cls_addr;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // configuration writes
   always_comb begin
      nets_in = nets_ff;
      if (csr_write_en && csr_index == CSR_NETS_IN_USE) nets_in = csr_wdata[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nets_ff <= '0;
         for (int k = 0; k < NET_REGS; k++) net_ff[k] <= '0;
      end else begin
         nets_ff <= nets_in;
         for (int k = 0; k < NET_REGS; k++) begin
            if (csr_write_en && csr_index == 3'(k + 1)) net_ff[k] <= csr_wdata;
         end
      end
   end

   // first hit over the active prefixes, source before destination per prefix
   always_comb begin
      n_used = (nets_ff > 3'(MAX_LOCAL_NETS)) ? 3'(MAX_LOCAL_NETS) : nets_ff;
      found = 1'b0;
      cls_status = ST_NOT_LOCAL;
      cls_addr = '0;
      for (int k = 0; k < MAX_LOCAL_NETS; k++) begin
         if (!found && 3'(k) < n_used) begin
            if (prefix_hit(in_src_addr, net_ff[k])) begin
               found = 1'b1;
               cls_status = ST_SRC;
               cls_addr = in_src_addr;
            end else if (prefix_hit(in_dst_addr, net_ff[k])) begin
               found = 1'b1;
               cls_status = ST_DST;
               cls_addr = in_dst_addr;
            end
         end
      end
   end

   // job toward the back, unused mode is dropped
   always_comb begin
      push_job.mode         = in_mode;
      push_job.status       = cls_status;
      push_job.seq_gap      = (in_log_seq != exp_seq_ff);
      push_job.addr         = cls_addr;
      push_job.total_length = in_total_length;
      push_job.timestamp    = in_timestamp;
      push_job.read_index   = in_read_index;
      push = accept && (in_mode == MODE_PKT || in_mode == MODE_READ ||
                        in_mode == MODE_FLUSH);
      exp_seq_in = exp_seq_ff;
      if (accept && in_mode == MODE_PKT) exp_seq_in = in_log_seq + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) exp_seq_ff <= '0;
      else exp_seq_ff <= exp_seq_in;
   end

endmodule

/* src/hta_queue.sv */
// ----------------------------------------------------------------------------
// hta_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module hta_queue
   import hta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

/* src/hta_back.sv */
// ----------------------------------------------------------------------------
// hta_back
// Table engine: sequential host search, entry update, read and flush,
// with the result register.
// ----------------------------------------------------------------------------
module hta_back
   import hta_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_not_empty,
   input  job_type head,
   output logic    pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_RDO  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] ent_ff, ent_in;
   logic             fresh_ff, fresh_in;
   rsp_type          rsp_ff, rsp_in;

   // table storage, used entries always form the range below fill
   logic [31:0]      addr_mem [TABLE_ENTRIES];
   entry_type        data_mem [TABLE_ENTRIES];
   logic [31:0]      addr_rd_ff;
   entry_type        data_rd_ff;
   logic [IDX_W-1:0] raddr;
   logic             aw_en, dw_en;
   logic [IDX_W-1:0] aw_idx;
   entry_type        dw_data;

   logic [10:0]      ridx_w;
   logic             rd_hit;
   logic             hit;
   entry_type        old_e, new_e;

   assign out_valid = (state_ff == S_OUT);
   assign out_rsp   = rsp_ff;

   // counter update for the chosen entry
   always_comb begin
      old_e = fresh_ff ? '0 : data_rd_ff;
      new_e = old_e;
      if (job_ff.status == ST_SRC) begin
         new_e.src_packets = old_e.src_packets + 64'd1;
         new_e.src_bytes   = old_e.src_bytes + 64'(job_ff.total_length);
      end else begin
         new_e.dst_packets = old_e.dst_packets + 64'd1;
         new_e.dst_bytes   = old_e.dst_bytes + 64'(job_ff.total_length);
      end
      if (old_e.first_stamp == 32'd0) new_e.first_stamp = job_ff.timestamp;
      new_e.last_stamp = job_ff.timestamp;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      fill_in    = fill_ff;
      scan_in    = scan_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      ent_in     = ent_ff;
      fresh_in   = fresh_ff;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      raddr      = scan_ff[IDX_W-1:0];
      aw_en      = 1'b0;
      aw_idx     = fill_ff[IDX_W-1:0];
      dw_en      = 1'b0;
      dw_data    = new_e;
      ridx_w     = 11'(head.read_index);
      rd_hit     = (ridx_w < 11'(TABLE_ENTRIES)) && (ridx_w < 11'(fill_ff));
      hit        = cmp_vld_ff && (addr_rd_ff == job_ff.addr);
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               pop    = 1'b1;
               job_in = head;
               rsp_in = '0;
               case (head.mode)
                  MODE_FLUSH: begin
                     fill_in       = '0;
                     rsp_in.status = ST_FLUSHED;
                     state_in      = S_OUT;
                  end
                  MODE_READ: begin
                     rsp_in.status      = ST_READ;
                     rsp_in.entry_index = head.read_index;
                     raddr              = ridx_w[IDX_W-1:0];
                     state_in           = rd_hit ? S_RDO : S_OUT;
                  end
                  default: begin
                     rsp_in.status  = head.status;
                     rsp_in.seq_gap = head.seq_gap;
                     if (head.status == ST_NOT_LOCAL) begin
                        state_in = S_OUT;
                     end else begin
                        scan_in    = '0;
                        cmp_vld_in = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               ent_in   = cmp_idx_ff;
               raddr    = cmp_idx_ff;
               fresh_in = 1'b0;
               state_in = S_UPD;
            end else if (scan_ff == fill_ff) begin
               if (fill_ff == CNT_W'(TABLE_ENTRIES)) begin
                  rsp_in.status    = ST_FULL;
                  rsp_in.host_addr = job_ff.addr;
                  state_in         = S_OUT;
               end else begin
                  aw_en    = 1'b1;
                  ent_in   = fill_ff[IDX_W-1:0];
                  fill_in  = fill_ff + CNT_W'(1);
                  fresh_in = 1'b1;
                  state_in = S_UPD;
               end
            end else begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end
         S_UPD: begin
            dw_en              = 1'b1;
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry_index = 5'(ent_ff);
            rsp_in.host_addr   = job_ff.addr;
            rsp_in.data        = new_e;
            state_in           = S_OUT;
         end
         S_RDO: begin
            rsp_in.entry_valid = 1'b1;
            rsp_in.host_addr   = addr_rd_ff;
            rsp_in.data        = data_rd_ff;
            state_in           = S_OUT;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      ent_ff     <= ent_in;
      fresh_ff   <= fresh_in;
      rsp_ff     <= rsp_in;
   end

   // table memories, registered reads
   always_ff @(posedge clock) begin
      if (aw_en) addr_mem[aw_idx] <= job_ff.addr;
      addr_rd_ff <= addr_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (dw_en) data_mem[ent_ff] <= dw_data;
      data_rd_ff <= data_mem[raddr];
   end

endmodule

/* src/hta_checker.sv */
// ----------------------------------------------------------------------------
// hta_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module hta_checker
   import hta_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic       rsp_entry_valid,
   input logic [4:0] rsp_entry_index
);

   // a pending response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   // only counted or read entries report a valid entry
   a_valid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |->
         rsp_status == ST_SRC || rsp_status == ST_DST || rsp_status == ST_READ)
      else $error("entry valid with wrong status");

   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FLUSHED)
      else $error("undefined status");

   // flush result carries no entry
   a_flush_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FLUSHED |->
         !rsp_entry_valid && rsp_entry_index == 5'd0)
      else $error("flush result not clear");

endmodule

bind host_traffic_accounting_table_top hta_checker u_hta_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_status(rsp.status),
   .rsp_entry_valid(rsp.entry_valid),
   .rsp_entry_index(rsp.entry_index)
);
